/* src/mi4_pkg.sv */
// Shared types, defaults and permutation tables for the 4x4 matrix inverse.
package mi4_pkg;

   localparam int DEF_FRAC_BITS = 16;
   localparam int DEF_WORD_BITS = 32;
   localparam int ELEM_COUNT    = 16;
   localparam int ADDR_BITS     = 4;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_MUL,
      ST_ADD,
      ST_TERM,
      ST_SETUP,
      ST_DIV,
      ST_OUT
   } state_type;

   // All permutations of four columns, digit f in bits [2f+1:2f]
   localparam logic [7:0] P4_TBL [24] = '{
      {2'd3,2'd2,2'd1,2'd0}, {2'd2,2'd3,2'd1,2'd0}, {2'd3,2'd1,2'd2,2'd0},
      {2'd1,2'd3,2'd2,2'd0}, {2'd2,2'd1,2'd3,2'd0}, {2'd1,2'd2,2'd3,2'd0},
      {2'd3,2'd2,2'd0,2'd1}, {2'd2,2'd3,2'd0,2'd1}, {2'd3,2'd0,2'd2,2'd1},
      {2'd0,2'd3,2'd2,2'd1}, {2'd2,2'd0,2'd3,2'd1}, {2'd0,2'd2,2'd3,2'd1},
      {2'd3,2'd1,2'd0,2'd2}, {2'd1,2'd3,2'd0,2'd2}, {2'd3,2'd0,2'd1,2'd2},
      {2'd0,2'd3,2'd1,2'd2}, {2'd1,2'd0,2'd3,2'd2}, {2'd0,2'd1,2'd3,2'd2},
      {2'd2,2'd1,2'd0,2'd3}, {2'd1,2'd2,2'd0,2'd3}, {2'd2,2'd0,2'd1,2'd3},
      {2'd0,2'd2,2'd1,2'd3}, {2'd1,2'd0,2'd2,2'd3}, {2'd0,2'd1,2'd2,2'd3}
   };
   localparam logic [23:0] P4_ODD = 24'h666666;

   // All permutations of three columns
   localparam logic [5:0] P3_TBL [6] = '{
      {2'd2,2'd1,2'd0}, {2'd1,2'd2,2'd0}, {2'd2,2'd0,2'd1},
      {2'd0,2'd2,2'd1}, {2'd1,2'd0,2'd2}, {2'd0,2'd1,2'd2}
   };
   localparam logic [5:0] P3_ODD = 6'b100110;

endpackage

/* src/mi4_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mi4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/matrix_inverse_4x4_top.sv */
// Top level of the 4x4 fixed-point matrix inverse (adjugate over determinant).
//
// Elements are written one beat at a time into a 16-word RAM (zero after reset;
// words not rewritten keep their value). A beat with last_element set writes
// its element and starts a run; the input stalls until the run is done. The
// determinant is the sum of 24 signed four-fold products; each of the 16 results
// then takes one cofactor (6 three-fold products) and a restoring division of
// WORD_BITS+1 quotient steps. All products go through one WORD_BITS x WORD_BITS
// multiplier working on magnitudes limb by limb, fed by the single RAM read
// port, one element per read. A run also waits whenever the output stalls.
// A singular matrix skips the cofactors and gives 16 zero beats flagged
// singular. Results are rounded to nearest, ties away from zero, then saturated.
module matrix_inverse_4x4_top
   import mi4_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [3:0]                  req_element_index,
   input  logic signed [WORD_BITS-1:0] req_element_value,
   input  logic                        req_last_element,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [3:0]                  rsp_result_index,
   output logic signed [WORD_BITS-1:0] rsp_result_value,
   output logic                        rsp_singular,
   output logic                        rsp_saturated,
   output logic                        rsp_last_result
);

   localparam int W   = WORD_BITS;
   localparam int PW  = 4 * W;          // product magnitude
   localparam int AW  = 4 * W + 2;      // signed sums
   localparam int XW  = (3 * W + 2 * FRAC_BITS + 2 > 5 * W + 2) ?
                        3 * W + 2 * FRAC_BITS + 3 : 5 * W + 3;
   localparam int BCW = $clog2(W + 1);
   localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

   state_type state_ff, state_in;
   logic            phase_ff, phase_in;      // 1 = determinant pass
   logic [3:0]      k_ff, k_in;
   logic [4:0]      term_ff, term_in;
   logic [1:0]      fac_ff, fac_in;
   logic [1:0]      limb_ff, limb_in;
   logic            sign_ff, sign_in;
   logic [W-1:0]    x_ff, x_in;
   logic [PW-1:0]   p_ff, p_in;
   logic [PW-1:0]   q_ff, q_in;
   logic [2*W-1:0]  mul_ff, mul_in;
   logic [AW-1:0]   acc_ff, acc_in;
   logic [AW-1:0]   det_ff, det_in;
   logic [XW-1:0]   rem_ff, rem_in;
   logic [XW-1:0]   dsh_ff, dsh_in;
   logic [W:0]      quo_ff, quo_in;
   logic [BCW-1:0]  bit_ff, bit_in;
   logic [ELEM_COUNT-1:0] valid_ff, valid_in;
   logic            rd_ok_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [3:0]      rsp_index_ff, rsp_index_in;
   logic [W-1:0]    rsp_value_ff, rsp_value_in;
   logic            rsp_sing_ff, rsp_sing_in;
   logic            rsp_sat_ff, rsp_sat_in;
   logic            rsp_last_ff, rsp_last_in;

   logic                 req_acc;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [W-1:0]         ram_rdata;
   logic [W-1:0]         elem;
   logic                 elem_neg;
   logic [W-1:0]         elem_mag;
   logic [7:0]           perm4;
   logic [5:0]           perm3;
   logic [1:0]           cof_row, cof_col, d4, d3, rr, cc;
   logic                 term_sign, last_term, last_fac;
   logic [AW-1:0]        acc_sum, p_ext;
   logic [PW-1:0]        q_sum;
   logic [AW-1:0]        cmag, dmag;
   logic [XW-1:0]        diff;
   logic                 ge, det_zero, out_free, neg, over;
   logic [W-1:0]         qv, mag;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   mi4_ram #(.WIDTH(W), .DEPTH(ELEM_COUNT)) u_store (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (req_element_index),
      .wr_data (req_element_value),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // element addressing for the current product factor
   always_comb begin
      perm4   = P4_TBL[term_ff];
      perm3   = P3_TBL[term_ff[2:0]];
      cof_row = k_ff[1:0];   // result (i,j) uses cofactor (j,i)
      cof_col = k_ff[3:2];
      d4      = perm4[fac_ff*2 +: 2];
      d3      = perm3[fac_ff*2 +: 2];
      rr      = fac_ff + {1'b0, (fac_ff >= cof_row)};
      cc      = d3 + {1'b0, (d3 >= cof_col)};
      rd_addr = phase_ff ? {fac_ff, d4} : {rr, cc};
      term_sign = phase_ff ? P4_ODD[term_ff]
                           : (P3_ODD[term_ff[2:0]] ^ cof_row[0] ^ cof_col[0]);
      last_term = phase_ff ? (term_ff == 5'd23) : (term_ff == 5'd5);
      last_fac  = phase_ff ? (fac_ff == 2'd3) : (fac_ff == 2'd2);
   end

   always_comb begin
      elem     = rd_ok_ff ? ram_rdata : '0;
      elem_neg = elem[W-1];
      elem_mag = elem_neg ? (~elem + 1'b1) : elem;
      p_ext    = {2'b00, p_ff};
      acc_sum  = acc_ff + (sign_ff ? (~p_ext + 1'b1) : p_ext);
      q_sum    = q_ff + (PW'(mul_ff) << (limb_ff * W));
      cmag     = acc_ff[AW-1] ? (~acc_ff + 1'b1) : acc_ff;
      dmag     = det_ff[AW-1] ? (~det_ff + 1'b1) : det_ff;
      diff     = rem_ff - dsh_ff;
      ge       = (rem_ff >= dsh_ff);
      det_zero = (det_ff == '0);
      out_free = !rsp_valid_ff || !rsp_stall;
      neg      = acc_ff[AW-1] ^ det_ff[AW-1];
      qv       = quo_ff[W-1:0];
      over     = quo_ff[W] || (neg ? (qv > HALF) : qv[W-1]);
      mag      = over ? (neg ? HALF : HALF - 1'b1) : qv;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      k_in     = k_ff;
      term_in  = term_ff;
      fac_in   = fac_ff;
      limb_in  = limb_ff;
      sign_in  = sign_ff;
      x_in     = x_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      mul_in   = mul_ff;
      acc_in   = acc_ff;
      det_in   = det_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      bit_in   = bit_ff;
      valid_in = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sing_in  = rsp_sing_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_acc) begin
         valid_in[req_element_index] = 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_last_element) begin
               phase_in = 1'b1;
               term_in  = '0;
               fac_in   = '0;
               acc_in   = '0;
               k_in     = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            x_in = elem_mag;
            if (fac_ff == 2'd0) begin
               sign_in  = term_sign ^ elem_neg;
               p_in     = PW'(elem_mag);
               state_in = ST_TERM;
            end else begin
               sign_in  = sign_ff ^ elem_neg;
               q_in     = '0;
               limb_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_in   = p_ff[limb_ff*W +: W] * x_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (limb_ff == fac_ff - 2'd1) begin
               p_in     = q_sum;
               state_in = ST_TERM;
            end else begin
               q_in     = q_sum;
               limb_in  = limb_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_TERM: begin
            if (!last_fac) begin
               fac_in   = fac_ff + 2'd1;
               state_in = ST_READ;
            end else begin
               fac_in = '0;
               acc_in = acc_sum;
               if (!last_term) begin
                  term_in  = term_ff + 5'd1;
                  state_in = ST_READ;
               end else begin
                  term_in = '0;
                  if (phase_ff) begin
                     det_in   = acc_sum;
                     phase_in = 1'b0;
                     acc_in   = '0;
                     state_in = (acc_sum == '0) ? ST_OUT : ST_READ;
                  end else begin
                     state_in = ST_SETUP;
                  end
               end
            end
         end
         ST_SETUP: begin
            // 2|C|*2^(2F) + |det| over 2|det|, shifted divisor starts at bit W
            rem_in   = (XW'(cmag) << (2 * FRAC_BITS + 1)) + XW'(dmag);
            dsh_in   = XW'(dmag) << (W + 1);
            quo_in   = '0;
            bit_in   = BCW'(W);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = diff;
            end
            quo_in = {quo_ff[W-1:0], ge};
            dsh_in = dsh_ff >> 1;
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = k_ff;
               rsp_sing_in  = det_zero;
               rsp_last_in  = (k_ff == 4'd15);
               rsp_sat_in   = det_zero ? 1'b0 : over;
               rsp_value_in = det_zero ? '0 : (neg ? (~mag + 1'b1) : mag);
               if (k_ff == 4'd15) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 4'd1;
                  acc_in   = '0;
                  term_in  = '0;
                  fac_in   = '0;
                  state_in = det_zero ? ST_OUT : ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         valid_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         valid_ff     <= valid_in;
         rd_ok_ff     <= valid_ff[rd_addr];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      term_ff      <= term_in;
      fac_ff       <= fac_in;
      limb_ff      <= limb_in;
      sign_ff      <= sign_in;
      x_ff         <= x_in;
      p_ff         <= p_in;
      q_ff         <= q_in;
      mul_ff       <= mul_in;
      acc_ff       <= acc_in;
      det_ff       <= det_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quo_ff       <= quo_in;
      bit_ff       <= bit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sing_ff  <= rsp_sing_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_singular     = rsp_sing_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule
